@@ rtl/core/event_calendar_priority_queue_core_macros.svh @@
// Assertion macros for the event calendar checker.
// Each one expects clk and arst_n in scope.
`ifndef EVENT_CALENDAR_PRIORITY_QUEUE_CORE_MACROS_SVH
`define EVENT_CALENDAR_PRIORITY_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ECPQ_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("event calendar check failed");

// Next-cycle implication, disabled during reset.
`define ECPQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("event calendar check failed");

`endif

@@ rtl/core/ecpq_pkg.sv @@
package ecpq_pkg;

	// Queue depth and count width
	localparam int CAPACITY = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int OCC_W    = 7;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_POP    = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// One stored calendar entry
	typedef struct packed {
		logic [31:0] event_time;
		logic [2:0]  event_kind;
		logic [1:0]  entity_kind;
		logic [9:0]  entity_number;
	} entry_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] event_time;
		logic [2:0]  event_kind;
		logic [1:0]  entity_kind;
		logic [9:0]  entity_number;
	} item_t;

	typedef struct packed {
		logic             pop_valid;
		logic [31:0]      out_time;
		logic [2:0]       out_event_kind;
		logic [1:0]       out_entity_kind;
		logic [9:0]       out_entity_number;
		status_t          status;
		logic [OCC_W-1:0] occupancy;
	} result_t;

	// Per-cycle command broadcast to every cell
	typedef struct packed {
		logic ins;
		logic pop;
	} cell_ctrl_t;

endpackage

@@ rtl/core/event_calendar_priority_queue_core.sv @@
// Sorted event calendar, up to ecpq_pkg::CAPACITY entries, earliest time at
// the head. Busy never rises, so a new insert or pop may be started in
// every clock cycle, and its result appears with done high in the cycle
// after start. Done is high for that single cycle and the result is held
// only until the next accepted item; the receiver must take it then. The
// queue is a chain of cells, one entry per cell, each with its own 32-bit
// key compare, so the cycle time is one compare plus a two-level select per
// cell. Ties leave newest first. A pop on an empty queue reports the empty
// status, an insert on a full queue is dropped with the full status. No
// clearing pass follows reset; the queue is usable at once.
module event_calendar_priority_queue_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ecpq_pkg::item_t   item,
	output logic              done,
	output ecpq_pkg::result_t result
);

	localparam int N = ecpq_pkg::CAPACITY;

	logic [ecpq_pkg::CNT_W-1:0] count_q;
	logic [ecpq_pkg::CNT_W-1:0] count_nxt;
	logic                       accept;
	logic                       is_full;
	logic                       is_empty;
	ecpq_pkg::cell_ctrl_t       ctrl;
	ecpq_pkg::entry_t           new_entry;
	ecpq_pkg::entry_t           cell_entry [N];
	logic                       cell_ge    [N];
	logic                       done_q;
	ecpq_pkg::result_t          result_q;
	ecpq_pkg::result_t          result_nxt;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign is_full  = (count_q == ecpq_pkg::CNT_W'(N));
	assign is_empty = (count_q == '0);

	assign new_entry.event_time    = item.event_time;
	assign new_entry.event_kind    = item.event_kind;
	assign new_entry.entity_kind   = item.entity_kind;
	assign new_entry.entity_number = item.entity_number;

	// Decode the command for the cell row
	always_comb begin
		ctrl.ins = accept && (item.op == ecpq_pkg::OP_INSERT) && !is_full;
		ctrl.pop = accept && (item.op == ecpq_pkg::OP_POP) && !is_empty;
	end

	// Build the chain of cells
	for (genvar i = 0; i < N; i++) begin : g_cell
		ecpq_pkg::entry_t left_entry;
		ecpq_pkg::entry_t right_entry;
		logic             left_ge;

		if (i == 0) begin : g_head
			assign left_entry = new_entry;
			assign left_ge    = 1'b0;
		end else begin : g_body
			assign left_entry = cell_entry[i-1];
			assign left_ge    = cell_ge[i-1];
		end

		if (i == N - 1) begin : g_tail
			assign right_entry = cell_entry[i];
		end else begin : g_inner
			assign right_entry = cell_entry[i+1];
		end

		ecpq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.new_entry   (new_entry),
			.left_entry  (left_entry),
			.left_ge     (left_ge),
			.right_entry (right_entry),
			.occupied    (count_q > ecpq_pkg::CNT_W'(i)),
			.entry       (cell_entry[i]),
			.ge          (cell_ge[i])
		);
	end

	// Next count
	always_comb begin
		count_nxt = count_q;
		if (ctrl.ins) begin
			count_nxt = count_q + 1'b1;
		end else if (ctrl.pop) begin
			count_nxt = count_q - 1'b1;
		end
	end

	// Form the result of the current transaction
	always_comb begin
		result_nxt                   = '0;
		result_nxt.status            = ecpq_pkg::ST_OK;
		result_nxt.occupancy         = ecpq_pkg::OCC_W'(count_nxt);
		if (item.op == ecpq_pkg::OP_POP) begin
			if (is_empty) begin
				result_nxt.status = ecpq_pkg::ST_EMPTY;
			end else begin
				result_nxt.pop_valid         = 1'b1;
				result_nxt.out_time          = cell_entry[0].event_time;
				result_nxt.out_event_kind    = cell_entry[0].event_kind;
				result_nxt.out_entity_kind   = cell_entry[0].entity_kind;
				result_nxt.out_entity_number = cell_entry[0].entity_number;
			end
		end else if (is_full) begin
			result_nxt.status = ecpq_pkg::ST_FULL;
		end
	end

	// Hold count and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_nxt;
			done_q  <= accept;
		end
	end

	// Register the result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result_nxt;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

@@ rtl/core/ecpq_cell.sv @@
module ecpq_cell (
	input  logic                clk,
	input  ecpq_pkg::cell_ctrl_t ctrl,
	input  ecpq_pkg::entry_t    new_entry,
	input  ecpq_pkg::entry_t    left_entry,
	input  logic                left_ge,
	input  ecpq_pkg::entry_t    right_entry,
	input  logic                occupied,
	output ecpq_pkg::entry_t    entry,
	output logic                ge
);

	ecpq_pkg::entry_t entry_q;

	// Flag cells that must make room for the new key (empty cells too)
	assign ge    = !occupied || (entry_q.event_time >= new_entry.event_time);
	assign entry = entry_q;

	// Insert: shift right past the insertion point, load new entry there.
	// Pop: shift everything one place toward the head.
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (left_ge) begin
				entry_q <= left_entry;
			end else if (ge) begin
				entry_q <= new_entry;
			end
		end else if (ctrl.pop) begin
			entry_q <= right_entry;
		end
	end

endmodule

@@ rtl/core/ecpq_checker.sv @@
`include "event_calendar_priority_queue_core_macros.svh"

module ecpq_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input ecpq_pkg::result_t result
);

	// Every accepted transaction strobes a result in the next cycle, and only then
	`ECPQ_ASSERT_NEXT(a_done_follows, start && !busy, done)
	`ECPQ_ASSERT_NEXT(a_no_spurious_done, !(start && !busy), !done)
	// A pop on an empty queue leaves it empty
	`ECPQ_ASSERT_NOW(a_empty_occ, done && (result.status == ecpq_pkg::ST_EMPTY), result.occupancy == '0)
	// A returned event always carries the ok status
	`ECPQ_ASSERT_NOW(a_pop_ok, done && result.pop_valid, result.status == ecpq_pkg::ST_OK)
	// A dropped insert reports a full queue
	`ECPQ_ASSERT_NOW(a_full_occ, done && (result.status == ecpq_pkg::ST_FULL), result.occupancy == ecpq_pkg::OCC_W'(ecpq_pkg::CAPACITY))

endmodule

bind event_calendar_priority_queue_core ecpq_checker u_ecpq_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

@@ tb/testbench.sv @@
module testbench;
	import ecpq_pkg::*;

	localparam int ITEMS_TARGET = 1800;
	localparam int STALL_LIMIT  = 500;

	// Keeps its own sorted calendar and the queue of results still to come
	class calendar_scoreboard;
		entry_t  calendar_copy[$];
		result_t expected_results[$];
		int      mismatches;
		int      results_seen;
		int      inserts;
		int      pops;
		int      pops_on_empty;
		int      inserts_on_full;
		int      max_occupancy;

		function new();
			mismatches      = 0;
			results_seen    = 0;
			inserts         = 0;
			pops            = 0;
			pops_on_empty   = 0;
			inserts_on_full = 0;
			max_occupancy   = 0;
		endfunction

		task report(string msg);
			mismatches++;
			if (mismatches <= 40)
				$display("mismatch at result %0d: %s", results_seen, msg);
		endtask

		task check_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report($sformatf("%s got %0h expected %0h", name, got, want));
		endtask

		// Apply one accepted command to the calendar copy and queue its result
		function void predict_command(item_t cmd);
			result_t r;
			entry_t  e;
			int      pos;
			r = '0;
			r.status = ST_OK;
			if (cmd.op == OP_INSERT) begin
				inserts++;
				if (calendar_copy.size() >= CAPACITY) begin
					r.status = ST_FULL;
					inserts_on_full++;
				end else begin
					e.event_time    = cmd.event_time;
					e.event_kind    = cmd.event_kind;
					e.entity_kind   = cmd.entity_kind;
					e.entity_number = cmd.entity_number;
					// place ahead of every entry with an equal or later time
					pos = 0;
					while (pos < calendar_copy.size() &&
					       calendar_copy[pos].event_time < e.event_time)
						pos++;
					calendar_copy.insert(pos, e);
				end
			end else begin
				pops++;
				if (calendar_copy.size() == 0) begin
					r.status = ST_EMPTY;
					pops_on_empty++;
				end else begin
					e = calendar_copy.pop_front();
					r.pop_valid         = 1'b1;
					r.out_time          = e.event_time;
					r.out_event_kind    = e.event_kind;
					r.out_entity_kind   = e.entity_kind;
					r.out_entity_number = e.entity_number;
				end
			end
			r.occupancy = OCC_W'(calendar_copy.size());
			if (calendar_copy.size() > max_occupancy)
				max_occupancy = calendar_copy.size();
			expected_results.push_back(r);
		endfunction

		// Compare one result transaction with the oldest expectation
		task check_result(result_t got);
			result_t want;
			results_seen++;
			if (expected_results.size() == 0) begin
				report("result with no command outstanding");
			end else begin
				want = expected_results.pop_front();
				check_field("pop_valid", got.pop_valid, want.pop_valid);
				check_field("out_time", got.out_time, want.out_time);
				check_field("out_event_kind", got.out_event_kind, want.out_event_kind);
				check_field("out_entity_kind", got.out_entity_kind, want.out_entity_kind);
				check_field("out_entity_number", got.out_entity_number,
				            want.out_entity_number);
				check_field("status", got.status, want.status);
				check_field("occupancy", got.occupancy, want.occupancy);
			end
		endtask
	endclass

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	logic    done;
	item_t   item;
	result_t result;

	calendar_scoreboard sb;
	int                 items_sent;
	int                 stall_cycles;

	event_calendar_priority_queue_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	// Generate the clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Pick a time key: extremes, a narrow band that forces ties, or anything
	function automatic logic [31:0] rand_key();
		case ($urandom_range(0, 9))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			2, 3, 4: return 32'($urandom_range(0, 7));
			5:       return 32'hFFFF_FFF0 | 32'($urandom_range(0, 15));
			default: return $urandom;
		endcase
	endfunction

	function automatic item_t rand_item(int insert_pct);
		item_t it;
		it.op            = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_POP;
		it.event_time    = rand_key();
		it.event_kind    = 3'($urandom);
		it.entity_kind   = 2'($urandom);
		it.entity_number = 10'($urandom);
		return it;
	endfunction

	function automatic item_t make_item(op_t op, logic [31:0] t, logic [2:0] ek,
	                                    logic [1:0] nk, logic [9:0] num);
		item_t it;
		it.op            = op;
		it.event_time    = t;
		it.event_kind    = ek;
		it.entity_kind   = nk;
		it.entity_number = num;
		return it;
	endfunction

	// Issue one command transaction, with an occasional idle gap ahead of it
	task automatic issue(input item_t it);
		int gap;
		if (!(items_sent >= 700 && items_sent < 1100) && $urandom_range(0, 99) < 11) begin
			gap = $urandom_range(1, 2);
			repeat (gap) begin
				start <= 1'b0;
				item  <= rand_item(50);
				@(posedge clk);
			end
		end
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy !== 1'b0);
		items_sent++;
	endtask

	// Hold off until every outstanding result has come back
	task automatic wait_drained();
		start <= 1'b0;
		@(negedge clk);
		while (sb.expected_results.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// Watch both transaction types on the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done === 1'b1)
				sb.check_result(result);
			if (start && busy === 1'b0)
				sb.predict_command(item);
		end
	end

	// End the run when no transaction moves for too long
	initial begin
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && busy === 1'b0) || done === 1'b1)
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		int phase_len;
		int pct;
		bit paused;
		sb         = new();
		items_sent = 0;
		paused     = 1'b0;
		arst_n <= 1'b0;
		start  <= 1'b0;
		item   <= '0;

		// Hold reset, then release it
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty pop, extreme keys and tags, ties, drain past empty
		issue(make_item(OP_POP, 32'h0, 3'd0, 2'd0, 10'd0));
		issue(make_item(OP_INSERT, 32'hFFFF_FFFF, 3'd7, 2'd3, 10'd1023));
		issue(make_item(OP_INSERT, 32'h0, 3'd0, 2'd0, 10'd0));
		issue(make_item(OP_INSERT, 32'h0, 3'd5, 2'd1, 10'd1));
		issue(make_item(OP_INSERT, 32'd500, 3'd1, 2'd1, 10'd10));
		issue(make_item(OP_INSERT, 32'd500, 3'd2, 2'd2, 10'd20));
		issue(make_item(OP_INSERT, 32'd500, 3'd3, 2'd3, 10'd30));
		issue(make_item(OP_INSERT, 32'h8000_0000, 3'd6, 2'd2, 10'd512));
		repeat (8) issue(make_item(OP_POP, 32'hFFFF_FFFF, 3'd7, 2'd3, 10'd1023));
		issue(make_item(OP_POP, 32'h0, 3'd0, 2'd0, 10'd0));
		issue(make_item(OP_INSERT, 32'd7, 3'd4, 2'd0, 10'd341));
		issue(make_item(OP_POP, 32'h0, 3'd0, 2'd0, 10'd0));

		// Fill past capacity, then drain past empty, with random content
		repeat (CAPACITY + 6) issue(rand_item(100));
		repeat (CAPACITY + 6) issue(rand_item(0));

		// Random phases that lean toward filling, draining, or holding level
		while (items_sent < ITEMS_TARGET) begin
			case ($urandom_range(0, 3))
				0:       pct = 50;
				1:       pct = 90;
				2:       pct = 10;
				default: pct = 65;
			endcase
			phase_len = $urandom_range(10, 50);
			repeat (phase_len) issue(rand_item(pct));
			if (!paused && items_sent >= 900) begin
				wait_drained();
				paused = 1'b1;
			end
		end

		// Wait out every outstanding result, then idle before the report
		wait_drained();
		repeat (5) @(posedge clk);

		$display("covered %0d inserts (%0d dropped on full) and %0d pops (%0d on empty)",
		         sb.inserts, sb.inserts_on_full, sb.pops, sb.pops_on_empty);
		$display("checked %0d results, peak occupancy %0d, %0d mismatches",
		         sb.results_seen, sb.max_occupancy, sb.mismatches);
		if (sb.mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

@@ event_calendar_priority_queue_core.f @@
+incdir+rtl/core
rtl/core/ecpq_pkg.sv
rtl/core/ecpq_cell.sv
rtl/core/event_calendar_priority_queue_core.sv
rtl/core/ecpq_checker.sv
tb/testbench.sv
